FILE: rtl/soft_knee_compressor_curve_defines.svh
// ----------------------------------------------------------------------------
// Soft knee compressor curve assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef SOFT_KNEE_COMPRESSOR_CURVE_DEFINES_SVH
`define SOFT_KNEE_COMPRESSOR_CURVE_DEFINES_SVH

// check while out of reset
`define SKCC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check at every edge
`define SKCC_ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/skcc_pkg.sv
// ----------------------------------------------------------------------------
// skcc_pkg
// Types, register codes and curve tables of the soft knee compressor curve.
// ----------------------------------------------------------------------------
package skcc_pkg;

  localparam int DB_FRAC_BITS = 8;
  localparam int LVL_W        = 16;
  localparam int GR_W         = 16;
  localparam int GRS_W        = 15;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [13:0] LOG2_10_OVER_20_Q16 = 14'd10885;
  localparam logic [18:0] DB_PER_OCTAVE_Q16   = 19'd394566;
  localparam int          FLOOR_DB            = 120;
  localparam int          FLOOR_LVL           = -(FLOOR_DB << DB_FRAC_BITS);

  localparam logic [16:0] EXP_TAB [9] = '{
    17'd65536, 17'd60097, 17'd55109, 17'd50535, 17'd46341,
    17'd42495, 17'd38968, 17'd35734, 17'd32768
  };
  localparam logic [16:0] LOG_TAB [9] = '{
    17'd0,     17'd11136, 17'd21098, 17'd30109, 17'd38336,
    17'd45904, 17'd52911, 17'd59434, 17'd65536
  };

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_RATIO     = 3'd1,
    REG_KNEE      = 3'd2,
    REG_MAKEUP    = 3'd3,
    REG_TRIM      = 3'd4,
    REG_MIX       = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    GR_ZERO = 2'd0,
    GR_HARD = 2'd1,
    GR_SOFT = 2'd2
  } gr_mode_t;

  typedef struct packed {
    logic signed [15:0] threshold_db;
    logic        [14:0] ratio;
    logic        [12:0] knee_db;
    logic signed [14:0] makeup_db;
    logic signed [13:0] output_trim_db;
    logic        [8:0]  mix;
  } cfg_t;

endpackage

FILE: rtl/skcc_regs.sv
// ----------------------------------------------------------------------------
// skcc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module skcc_regs import skcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.threshold_db   <= -16'sd5120;
      cfg_r.ratio          <= 15'd1024;
      cfg_r.knee_db        <= 13'd1536;
      cfg_r.makeup_db      <= '0;
      cfg_r.output_trim_db <= '0;
      cfg_r.mix            <= 9'd256;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD: cfg_r.threshold_db   <= signed'(pwdata[15:0]);
        REG_RATIO:     cfg_r.ratio          <= pwdata[14:0];
        REG_KNEE:      cfg_r.knee_db        <= pwdata[12:0];
        REG_MAKEUP:    cfg_r.makeup_db      <= signed'(pwdata[14:0]);
        REG_TRIM:      cfg_r.output_trim_db <= signed'(pwdata[13:0]);
        REG_MIX:       cfg_r.mix            <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = DATA_W'(cfg_r.threshold_db);
      REG_RATIO:     prdata = DATA_W'(cfg_r.ratio);
      REG_KNEE:      prdata = DATA_W'(cfg_r.knee_db);
      REG_MAKEUP:    prdata = DATA_W'(cfg_r.makeup_db);
      REG_TRIM:      prdata = DATA_W'(cfg_r.output_trim_db);
      REG_MIX:       prdata = DATA_W'(cfg_r.mix);
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: rtl/skcc_gr.sv
// ----------------------------------------------------------------------------
// skcc_gr
// Gain reduction pipeline: knee select, products, 16-stage restoring divider.
// ----------------------------------------------------------------------------
module skcc_gr import skcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_vld,
  input  logic signed [LVL_W-1:0] in_lvl,
  input  cfg_t                    cfg,
  output logic                    out_vld,
  output logic signed [LVL_W-1:0] out_lvl,
  output logic [GR_W-1:0]         out_gr
);

  localparam int REM_W = 47;
  localparam int DEN_W = 31;

  // stage 1: knee region
  logic [14:0]        r_eff, rm;
  logic signed [17:0] over;
  logic signed [18:0] over2, kk, x2w;
  logic               hard;
  gr_mode_t           mode_nxt;
  logic [15:0]        opa_nxt;
  logic [14:0]        opb_nxt;

  logic                    s1_vld_r;
  logic signed [LVL_W-1:0] s1_lvl_r;
  gr_mode_t                s1_mode_r;
  logic [15:0]             s1_opa_r;
  logic [14:0]             s1_opb_r, s1_rm_r, s1_r_r;
  logic [12:0]             s1_k_r;

  assign r_eff = (cfg.ratio < 15'd256) ? 15'd256 : cfg.ratio;
  assign rm    = r_eff - 15'd256;
  assign over  = 18'(in_lvl) - 18'(cfg.threshold_db);
  assign over2 = {over, 1'b0};
  assign kk    = signed'({6'd0, cfg.knee_db});
  assign hard  = (cfg.knee_db == '0) || (over2 >= kk);
  assign x2w   = over2 + kk;

  always_comb begin
    if (hard) begin
      mode_nxt = (over > 18'sd0) ? GR_HARD : GR_ZERO;
      opa_nxt  = over[15:0];
      opb_nxt  = rm;
    end else begin
      mode_nxt = (over2 <= -kk) ? GR_ZERO : GR_SOFT;
      opa_nxt  = {2'b00, x2w[13:0]};
      opb_nxt  = {1'b0, x2w[13:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (ce) begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_lvl_r  <= in_lvl;
      s1_mode_r <= mode_nxt;
      s1_opa_r  <= opa_nxt;
      s1_opb_r  <= opb_nxt;
      s1_rm_r   <= rm;
      s1_r_r    <= r_eff;
      s1_k_r    <= cfg.knee_db;
    end
  end

  // stage 2: first products
  logic [30:0]      p1_nxt;
  logic [27:0]      kr;
  logic [DEN_W-1:0] den2_nxt;

  logic                    s2_vld_r;
  logic signed [LVL_W-1:0] s2_lvl_r;
  gr_mode_t                s2_mode_r;
  logic [30:0]             s2_p1_r;
  logic [DEN_W-1:0]        s2_den_r;
  logic [14:0]             s2_rm_r;

  assign p1_nxt   = 31'(s1_opa_r) * 31'(s1_opb_r);
  assign kr       = 28'(s1_k_r) * 28'(s1_r_r);
  assign den2_nxt = (s1_mode_r == GR_SOFT) ? {kr, 3'b000} : DEN_W'(s1_r_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (ce) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_lvl_r  <= s1_lvl_r;
      s2_mode_r <= s1_mode_r;
      s2_p1_r   <= p1_nxt;
      s2_den_r  <= den2_nxt;
      s2_rm_r   <= s1_rm_r;
    end
  end

  // stage 3: numerator
  logic [42:0]      num_nxt;
  logic [DEN_W-1:0] den3_nxt;

  logic                    s3_vld_r;
  logic signed [LVL_W-1:0] s3_lvl_r;
  logic [42:0]             s3_num_r;
  logic [DEN_W-1:0]        s3_den_r;

  always_comb begin
    case (s2_mode_r)
      GR_SOFT: begin
        num_nxt  = 43'(s2_p1_r[27:0]) * 43'(s2_rm_r);
        den3_nxt = s2_den_r;
      end
      GR_HARD: begin
        num_nxt  = 43'(s2_p1_r);
        den3_nxt = s2_den_r;
      end
      default: begin
        num_nxt  = '0;
        den3_nxt = DEN_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (ce) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_lvl_r <= s2_lvl_r;
      s3_num_r <= num_nxt;
      s3_den_r <= den3_nxt;
    end
  end

  // stage 4 and divider: rounded quotient, one bit per stage
  logic                    vld_r [0:GR_W];
  logic signed [LVL_W-1:0] lvl_r [0:GR_W];
  logic [REM_W-1:0]        rem_r [0:GR_W];
  logic [DEN_W-1:0]        den_r [0:GR_W];
  logic [GR_W-1:0]         q_r   [0:GR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lvl_r[0] <= s3_lvl_r;
      rem_r[0] <= REM_W'(s3_num_r) + REM_W'(s3_den_r >> 1);
      den_r[0] <= s3_den_r;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < GR_W; j++) begin : g_div
    localparam int BIT = GR_W - 1 - j;
    logic [REM_W-1:0] dsh;
    logic [REM_W-1:0] rem_nxt;
    logic [GR_W-1:0]  q_nxt;

    assign dsh = REM_W'(den_r[j]) << BIT;

    always_comb begin
      if (rem_r[j] >= dsh) begin
        rem_nxt = rem_r[j] - dsh;
        q_nxt   = q_r[j] | (GR_W'(1) << BIT);
      end else begin
        rem_nxt = rem_r[j];
        q_nxt   = q_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (ce) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        lvl_r[j+1] <= lvl_r[j];
        rem_r[j+1] <= rem_nxt;
        den_r[j+1] <= den_r[j];
        q_r[j+1]   <= q_nxt;
      end
    end
  end

  assign out_vld = vld_r[GR_W];
  assign out_lvl = lvl_r[GR_W];
  assign out_gr  = q_r[GR_W];

endmodule

FILE: rtl/skcc_mix.sv
// ----------------------------------------------------------------------------
// skcc_mix
// Wet/dry levels, linear mix through exp/log tables, floor and saturation.
// ----------------------------------------------------------------------------
module skcc_mix import skcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    ce,
  input  logic                    in_vld,
  input  logic signed [LVL_W-1:0] in_lvl,
  input  logic [GR_W-1:0]         in_gr,
  input  cfg_t                    cfg,
  output logic                    out_vld,
  output logic signed [LVL_W-1:0] out_lvl,
  output logic [GRS_W-1:0]        out_grs
);

  // stage 1: wet, dry, weights
  logic [8:0]         mw, md;
  logic signed [17:0] wet, dry, dwd, base_nxt;
  logic               wge;
  logic [16:0]        delta_nxt;
  logic [GRS_W-1:0]   grs_nxt;

  logic               m1_vld_r, m1_byp_r;
  logic [GRS_W-1:0]   m1_grs_r;
  logic signed [17:0] m1_base_r;
  logic [8:0]         m1_wh_r, m1_wl_r;
  logic [16:0]        m1_delta_r;

  assign mw        = (cfg.mix > 9'd256) ? 9'd256 : cfg.mix;
  assign md        = 9'd256 - mw;
  assign wet       = 18'(in_lvl) - signed'({2'b00, in_gr}) + 18'(cfg.makeup_db)
                     + 18'(cfg.output_trim_db);
  assign dry       = 18'(in_lvl) + 18'(cfg.output_trim_db);
  assign wge       = (wet >= dry);
  assign dwd       = wet - dry;
  assign delta_nxt = wge ? dwd[16:0] : 17'(-dwd);
  assign grs_nxt   = in_gr[GR_W-1] ? {GRS_W{1'b1}} : in_gr[GRS_W-1:0];

  always_comb begin
    if (md == '0) begin
      base_nxt = wet;
    end else if (mw == '0) begin
      base_nxt = dry;
    end else begin
      base_nxt = wge ? wet : dry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
    end else if (ce) begin
      m1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m1_grs_r   <= grs_nxt;
      m1_base_r  <= base_nxt;
      m1_byp_r   <= (md == '0) || (mw == '0);
      m1_wh_r    <= wge ? mw : md;
      m1_wl_r    <= wge ? md : mw;
      m1_delta_r <= delta_nxt;
    end
  end

  // stage 2: exponent in log2 units
  logic [30:0] tp, tsum;

  logic               m2_vld_r, m2_byp_r;
  logic [GRS_W-1:0]   m2_grs_r;
  logic signed [17:0] m2_base_r;
  logic [8:0]         m2_wh_r, m2_wl_r;
  logic [21:0]        m2_t_r;

  assign tp   = 31'(m1_delta_r) * 31'(LOG2_10_OVER_20_Q16);
  assign tsum = tp + (31'(1) << (DB_FRAC_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_vld_r <= 1'b0;
    end else if (ce) begin
      m2_vld_r <= m1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m2_grs_r  <= m1_grs_r;
      m2_base_r <= m1_base_r;
      m2_byp_r  <= m1_byp_r;
      m2_wh_r   <= m1_wh_r;
      m2_wl_r   <= m1_wl_r;
      m2_t_r    <= 22'(tsum >> DB_FRAC_BITS);
    end
  end

  // stage 3: exp table interpolation product
  logic [3:0]  eidx;
  logic [16:0] ea, eb;
  logic [28:0] eprod;

  logic               m3_vld_r, m3_byp_r, m3_gz_r;
  logic [GRS_W-1:0]   m3_grs_r;
  logic signed [17:0] m3_base_r;
  logic [8:0]         m3_wh_r, m3_wl_r;
  logic [16:0]        m3_ea_r;
  logic [28:0]        m3_prod_r;
  logic [4:0]         m3_n_r;

  assign eidx  = {1'b0, m2_t_r[15:13]};
  assign ea    = EXP_TAB[eidx];
  assign eb    = EXP_TAB[eidx + 4'd1];
  assign eprod = 29'(ea - eb) * 29'(m2_t_r[12:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_vld_r <= 1'b0;
    end else if (ce) begin
      m3_vld_r <= m2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m3_grs_r  <= m2_grs_r;
      m3_base_r <= m2_base_r;
      m3_byp_r  <= m2_byp_r;
      m3_wh_r   <= m2_wh_r;
      m3_wl_r   <= m2_wl_r;
      m3_ea_r   <= ea;
      m3_prod_r <= eprod;
      m3_gz_r   <= (m2_t_r[21:16] > 6'd16);
      m3_n_r    <= m2_t_r[20:16];
    end
  end

  // stage 4: attenuation gain
  logic [29:0] ernd;
  logic [16:0] ev;

  logic               m4_vld_r, m4_byp_r;
  logic [GRS_W-1:0]   m4_grs_r;
  logic signed [17:0] m4_base_r;
  logic [8:0]         m4_wh_r, m4_wl_r;
  logic [16:0]        m4_g_r;

  assign ernd = 30'(m3_prod_r) + 30'd4096;
  assign ev   = m3_ea_r - 17'(ernd >> 13);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_vld_r <= 1'b0;
    end else if (ce) begin
      m4_vld_r <= m3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m4_grs_r  <= m3_grs_r;
      m4_base_r <= m3_base_r;
      m4_byp_r  <= m3_byp_r;
      m4_wh_r   <= m3_wh_r;
      m4_wl_r   <= m3_wl_r;
      m4_g_r    <= m3_gz_r ? 17'd0 : (ev >> m3_n_r);
    end
  end

  // stage 5: linear sum
  logic [25:0] wlg;

  logic               m5_vld_r, m5_byp_r;
  logic [GRS_W-1:0]   m5_grs_r;
  logic signed [17:0] m5_base_r;
  logic [24:0]        m5_s_r;

  assign wlg = 26'(m4_wl_r) * 26'(m4_g_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m5_vld_r <= 1'b0;
    end else if (ce) begin
      m5_vld_r <= m4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m5_grs_r  <= m4_grs_r;
      m5_base_r <= m4_base_r;
      m5_byp_r  <= m4_byp_r;
      m5_s_r    <= {m4_wh_r, 16'd0} + 25'(wlg);
    end
  end

  // stage 6: normalize
  logic [4:0]  pos;
  logic [24:0] un;

  logic               m6_vld_r, m6_byp_r;
  logic [GRS_W-1:0]   m6_grs_r;
  logic signed [17:0] m6_base_r;
  logic [4:0]         m6_p_r;
  logic [15:0]        m6_frac_r;

  always_comb begin
    pos = 5'd16;
    for (int i = 17; i < 25; i++) begin
      if (m5_s_r[i]) begin
        pos = 5'(i);
      end
    end
  end

  assign un = m5_s_r >> (pos - 5'd16);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m6_vld_r <= 1'b0;
    end else if (ce) begin
      m6_vld_r <= m5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m6_grs_r  <= m5_grs_r;
      m6_base_r <= m5_base_r;
      m6_byp_r  <= m5_byp_r;
      m6_p_r    <= pos;
      m6_frac_r <= un[15:0];
    end
  end

  // stage 7: log table interpolation product
  logic [3:0]  lidx;
  logic [16:0] la, lb;
  logic [29:0] lprod;

  logic               m7_vld_r, m7_byp_r;
  logic [GRS_W-1:0]   m7_grs_r;
  logic signed [17:0] m7_base_r;
  logic [4:0]         m7_p_r;
  logic [16:0]        m7_la_r;
  logic [29:0]        m7_prod_r;

  assign lidx  = {1'b0, m6_frac_r[15:13]};
  assign la    = LOG_TAB[lidx];
  assign lb    = LOG_TAB[lidx + 4'd1];
  assign lprod = 30'(lb - la) * 30'(m6_frac_r[12:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m7_vld_r <= 1'b0;
    end else if (ce) begin
      m7_vld_r <= m6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m7_grs_r  <= m6_grs_r;
      m7_base_r <= m6_base_r;
      m7_byp_r  <= m6_byp_r;
      m7_p_r    <= m6_p_r;
      m7_la_r   <= la;
      m7_prod_r <= lprod;
    end
  end

  // stage 8: octaves below full scale
  logic [30:0]        lrnd;
  logic [17:0]        lg;
  logic signed [22:0] aw;

  logic               m8_vld_r, m8_byp_r;
  logic [GRS_W-1:0]   m8_grs_r;
  logic signed [17:0] m8_base_r;
  logic [19:0]        m8_a_r;

  assign lrnd = 31'(m7_prod_r) + 31'd4096;
  assign lg   = 18'(m7_la_r) + 18'(lrnd >> 13);
  assign aw   = (23'sd24 <<< 16) - signed'({m7_p_r, 16'd0} + 23'(lg));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m8_vld_r <= 1'b0;
    end else if (ce) begin
      m8_vld_r <= m7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m8_grs_r  <= m7_grs_r;
      m8_base_r <= m7_base_r;
      m8_byp_r  <= m7_byp_r;
      m8_a_r    <= (aw < 23'sd0) ? 20'd0 : aw[19:0];
    end
  end

  // stage 9: scale to dB
  logic               m9_vld_r, m9_byp_r;
  logic [GRS_W-1:0]   m9_grs_r;
  logic signed [17:0] m9_base_r;
  logic [38:0]        m9_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m9_vld_r <= 1'b0;
    end else if (ce) begin
      m9_vld_r <= m8_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      m9_grs_r  <= m8_grs_r;
      m9_base_r <= m8_base_r;
      m9_byp_r  <= m8_byp_r;
      m9_prod_r <= 39'(m8_a_r) * 39'(DB_PER_OCTAVE_Q16);
    end
  end

  // stage 10: subtract, floor, saturate
  logic [39:0]        dsum;
  logic [15:0]        db;
  logic signed [18:0] res;
  logic signed [LVL_W-1:0] lvl_nxt;

  logic                    out_vld_r;
  logic signed [LVL_W-1:0] out_lvl_r;
  logic [GRS_W-1:0]        out_grs_r;

  assign dsum = 40'(m9_prod_r) + (40'(1) << (31 - DB_FRAC_BITS));
  assign db   = 16'(dsum >> (32 - DB_FRAC_BITS));
  assign res  = m9_byp_r ? 19'(m9_base_r) : (19'(m9_base_r) - signed'({3'b000, db}));

  always_comb begin
    if (res < 19'(FLOOR_LVL)) begin
      lvl_nxt = LVL_W'(FLOOR_LVL);
    end else if (res > 19'sd32767) begin
      lvl_nxt = 16'sd32767;
    end else begin
      lvl_nxt = res[LVL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (ce) begin
      out_vld_r <= m9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      out_lvl_r <= lvl_nxt;
      out_grs_r <= m9_grs_r;
    end
  end

  assign out_vld = out_vld_r;
  assign out_lvl = out_lvl_r;
  assign out_grs = out_grs_r;

endmodule

FILE: rtl/soft_knee_compressor_curve.sv
// ----------------------------------------------------------------------------
// soft_knee_compressor_curve
// Static soft knee compressor transfer curve with wet/dry mix.
//
//   channel   direction  handshake           payload
//   in        sink       in_valid/in_stall   in_input_level_db
//   out       source     out_valid/out_stall out_output_level_db, out_gain_reduction_db
//   cfg       slave      psel/penable/pready paddr, pwdata, prdata
//
// One transaction per cycle while out_stall does not hold the pipeline; the path has 30 register stages.
// The depth is set by the 16-stage quotient divider and the table mix path.
// The whole pipeline advances together; out_stall with out_valid holds it.
// rst_n is synchronous and clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module soft_knee_compressor_curve import skcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [LVL_W-1:0] in_input_level_db,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [LVL_W-1:0] out_output_level_db,
  output logic [GRS_W-1:0]        out_gain_reduction_db,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  cfg_t                    cfg;
  logic                    ce;
  logic                    gr_vld;
  logic signed [LVL_W-1:0] gr_lvl;
  logic [GR_W-1:0]         gr_val;

  assign ce       = !out_valid || !out_stall;
  assign in_stall = !ce;

  skcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  skcc_gr u_gr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (in_valid),
    .in_lvl  (in_input_level_db),
    .cfg     (cfg),
    .out_vld (gr_vld),
    .out_lvl (gr_lvl),
    .out_gr  (gr_val)
  );

  skcc_mix u_mix (
    .clk     (clk),
    .rst_n   (rst_n),
    .ce      (ce),
    .in_vld  (gr_vld),
    .in_lvl  (gr_lvl),
    .in_gr   (gr_val),
    .cfg     (cfg),
    .out_vld (out_valid),
    .out_lvl (out_output_level_db),
    .out_grs (out_gain_reduction_db)
  );

endmodule

FILE: rtl/skcc_checker.sv
// ----------------------------------------------------------------------------
// skcc_checker
// Port-level checks on the soft knee compressor curve, bound to the top.
// ----------------------------------------------------------------------------
`include "soft_knee_compressor_curve_defines.svh"

module skcc_checker import skcc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [LVL_W-1:0] out_output_level_db,
  input logic [GRS_W-1:0]        out_gain_reduction_db,
  input logic                    psel,
  input logic                    pready
);

  property p_out_hold;
    out_valid && out_stall |=>
      out_valid && $stable(out_output_level_db) && $stable(out_gain_reduction_db);
  endproperty

  property p_stall_src;
    in_stall == (out_valid && out_stall);
  endproperty

  property p_floor;
    out_valid |-> out_output_level_db >= -16'sd30720;
  endproperty

  `SKCC_ASSERT_RST(a_out_hold, p_out_hold, "stalled result changed")
  `SKCC_ASSERT_RST(a_stall_src, p_stall_src, "input stall without output stall")
  `SKCC_ASSERT_RST(a_floor, p_floor, "output below floor")
  `SKCC_ASSERT_ON(a_pready, psel |-> pready, "pready low")

endmodule

bind soft_knee_compressor_curve skcc_checker u_skcc_checker (.*);

FILE: tb/sv/skcc_curve_checker.sv
// ----------------------------------------------------------------------------
// skcc_curve_checker
// Tracks register writes on the configuration port, computes the expected
// output level and gain reduction of every accepted input level, and
// compares each accepted result against the oldest pending expectation.
// ----------------------------------------------------------------------------
module skcc_curve_checker import skcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [LVL_W-1:0] in_input_level_db,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [LVL_W-1:0] out_output_level_db,
  input  logic [GRS_W-1:0]        out_gain_reduction_db,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output int                      errors,
  output int                      pending
);

  typedef struct {
    logic signed [15:0] level;
    logic [14:0]        reduction;
  } curve_point_t;

  curve_point_t curve_q[$];
  cfg_t         cur;

  function automatic longint reduction_of(longint level);
    longint r, k, over, x2, num, den;
    r = (cur.ratio < 256) ? 256 : longint'(cur.ratio);
    k = longint'(cur.knee_db);
    over = level - longint'(cur.threshold_db);
    if (k == 0 || 2 * over >= k) begin
      if (over <= 0) return 0;
      return (over * (r - 256) + r / 2) / r;
    end
    if (2 * over <= -k) return 0;
    x2 = 2 * over + k;
    num = (r - 256) * x2 * x2;
    den = 8 * k * r;
    return (num + den / 2) / den;
  endfunction

  function automatic longint atten_q16(longint delta);
    longint t, n, f, idx, rr, v;
    t = (delta * 10885 + 128) >>> 8;
    n = t >>> 16;
    if (n > 16) return 0;
    f = t & 16'hFFFF;
    idx = f >>> 13;
    rr = f & 13'h1FFF;
    v = longint'(EXP_TAB[idx])
      - (((longint'(EXP_TAB[idx]) - longint'(EXP_TAB[idx + 1])) * rr + 4096) >>> 13);
    return v >>> n;
  endfunction

  function automatic longint drop_db(longint s);
    longint p, u, frac, idx, rr, lg, a;
    p = 16;
    while (p < 24 && (s >>> (p + 1)) != 0) p++;
    u = s >>> (p - 16);
    frac = (u - 65536) & 16'hFFFF;
    idx = frac >>> 13;
    rr = frac & 13'h1FFF;
    lg = longint'(LOG_TAB[idx])
       + (((longint'(LOG_TAB[idx + 1]) - longint'(LOG_TAB[idx])) * rr + 4096) >>> 13);
    a = (longint'(24) <<< 16) - ((p <<< 16) + lg);
    if (a < 0) a = 0;
    return (a * 394566 + (longint'(1) <<< 23)) >>> 24;
  endfunction

  function automatic curve_point_t curve_at(logic signed [15:0] lvl);
    curve_point_t pt;
    longint x, gr, wet, dry, mw, md, hi, wh, wl, delta, s, res;
    x = lvl;
    gr = reduction_of(x);
    wet = x - gr + longint'(cur.makeup_db) + longint'(cur.output_trim_db);
    dry = x + longint'(cur.output_trim_db);
    mw = (cur.mix > 256) ? 256 : longint'(cur.mix);
    md = 256 - mw;
    if (md == 0) res = wet;
    else if (mw == 0) res = dry;
    else begin
      hi = (wet >= dry) ? wet : dry;
      wh = (wet >= dry) ? mw : md;
      wl = (wet >= dry) ? md : mw;
      delta = (wet >= dry) ? wet - dry : dry - wet;
      s = wh * 65536 + wl * atten_q16(delta);
      res = hi - drop_db(s);
    end
    if (res < FLOOR_LVL) res = FLOOR_LVL;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    pt.level = res[15:0];
    pt.reduction = (gr > 32767) ? 15'h7FFF : gr[14:0];
    return pt;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    curve_point_t want;
    reg_idx_t idx;
    if (!rst_n) begin
      cur.threshold_db   <= -16'sd5120;
      cur.ratio          <= 15'd1024;
      cur.knee_db        <= 13'd1536;
      cur.makeup_db      <= '0;
      cur.output_trim_db <= '0;
      cur.mix            <= 9'd256;
      curve_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (curve_q.size() == 0) report_mismatch("unexpected transaction", 0, 0);
        else begin
          want = curve_q.pop_front();
          if (out_output_level_db !== want.level)
            report_mismatch("output_level_db", out_output_level_db, want.level);
          if (out_gain_reduction_db !== want.reduction)
            report_mismatch("gain_reduction_db", out_gain_reduction_db, want.reduction);
        end
      end
      if (in_valid && !in_stall) curve_q.push_back(curve_at(in_input_level_db));
      if (psel && penable && pwrite && pready) begin
        idx = reg_idx_t'(paddr[4:2]);
        case (idx)
          REG_THRESHOLD: cur.threshold_db   <= pwdata[15:0];
          REG_RATIO:     cur.ratio          <= pwdata[14:0];
          REG_KNEE:      cur.knee_db        <= pwdata[12:0];
          REG_MAKEUP:    cur.makeup_db      <= pwdata[14:0];
          REG_TRIM:      cur.output_trim_db <= pwdata[13:0];
          REG_MIX:       cur.mix            <= pwdata[8:0];
          default: ;
        endcase
      end
      pending <= curve_q.size();
    end
  end

endmodule

FILE: tb/sv/tb_soft_knee_compressor_curve.sv
// ----------------------------------------------------------------------------
// tb_soft_knee_compressor_curve
// Drives input levels and register settings into the compressor curve with
// random gaps and output stalls; a checker compares every result.
// ----------------------------------------------------------------------------
module tb_soft_knee_compressor_curve;
  import skcc_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LVL_W-1:0] in_input_level_db = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [LVL_W-1:0] out_output_level_db;
  logic [GRS_W-1:0]        out_gain_reduction_db;
  logic                    psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [DATA_W-1:0]       pwdata = '0;
  logic [DATA_W-1:0]       prdata;
  logic                    pready;
  int                      errors, pending;
  bit                      no_gaps = 1'b0;
  int                      thr = -5120, knee = 1536;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  soft_knee_compressor_curve u_top (.*);

  skcc_curve_checker u_checker (.*);

  initial begin
    #50_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_level(logic signed [15:0] lvl);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_input_level_db = lvl;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_curve(int t, int r, int k, int m, int tr, int mx);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_RATIO, r);
    write_reg(REG_KNEE, k);
    write_reg(REG_MAKEUP, m);
    write_reg(REG_TRIM, tr);
    write_reg(REG_MIX, mx);
    thr = $signed(t[15:0]);
    knee = k & 13'h1FFF;
  endtask

  function automatic logic signed [15:0] pick_level();
    int sel, span;
    sel = $urandom_range(0, 9);
    span = knee + 512;
    if (sel < 6) return 16'(thr + $signed($urandom_range(0, 2 * span)) - span);
    return 16'($urandom);
  endfunction

  task automatic run_phase(int n, bit hold_mid);
    for (int i = 0; i < n; i++) begin
      if (i % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (hold_mid && i == n / 2) drain();
      send_level(pick_level());
    end
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    logic signed [15:0] directed [$];
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    directed = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, -16'sd5120, -16'sd5888,
                 -16'sd4352, -16'sd5887, -16'sd4353, -16'sd4000, 16'sd8000};
    foreach (directed[i]) send_level(directed[i]);
    drain();
    set_curve(0, 25600, 0, 12288, 6144, 256);
    foreach (directed[i]) send_level(directed[i]);
    send_level(16'sd256);
    drain();
    set_curve(-24576, 100, 6144, -6144, -6144, 0);
    send_level(-16'sd32768);
    send_level(-16'sd30000);
    send_level(16'sd100);
    drain();
    set_curve(-24576, 25600, 6144, -6144, -6144, 128);
    send_level(-16'sd32768);
    send_level(-16'sd24576);
    send_level(16'sd32767);
    drain();
    set_curve(-5120, 1024, 1536, 0, 0, 511);
    run_phase(40, 1'b0);
    set_curve(-24576, 25600, 0, 12288, 6144, 1);
    run_phase(40, 1'b0);
    set_curve(0, 256, 6144, -6144, -6144, 255);
    run_phase(40, 1'b1);
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 0)
        set_curve($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      else
        set_curve(-$urandom_range(0, 24576), $urandom_range(256, 25600),
                  $urandom_range(0, 6144), $urandom_range(0, 18432) - 6144,
                  $urandom_range(0, 12288) - 6144, $urandom_range(0, 256));
      run_phase(55, ph == 4);
    end
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: soft_knee_compressor_curve.f
+incdir+rtl
rtl/skcc_pkg.sv
rtl/skcc_regs.sv
rtl/skcc_gr.sv
rtl/skcc_mix.sv
rtl/soft_knee_compressor_curve.sv
rtl/skcc_checker.sv
tb/sv/skcc_curve_checker.sv
tb/sv/tb_soft_knee_compressor_curve.sv
